/* rtl/core/hmp_pkg.sv */
// hmp_pkg: shared types and constants for the hash message padder
// used by hmp_front, hmp_queue, hmp_back and hash_message_padder_core
package hmp_pkg;

  localparam int WORD_W       = 64;
  localparam int BYTE_COUNT_W = 61;
  localparam int POS_W        = 4;
  localparam int MODE_W       = 2;
  localparam int VBYTES_W     = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [MODE_W-1:0] MODE_MD5    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHA256 = 2'd1;

  // register index 0 lives at byte address 0, index bit is paddr[2]
  localparam logic REG_HASH_MODE = 1'b0;

  localparam logic [POS_W-1:0] POS_LAST_NARROW = 4'd7;
  localparam logic [POS_W-1:0] POS_LAST_WIDE   = 4'd15;
  localparam logic [POS_W-1:0] POS_LEN_NARROW  = 4'd7;
  localparam logic [POS_W-1:0] POS_LEN_WIDE    = 4'd14;

  localparam logic [WORD_W-1:0] MARKER_WORD = 64'h8000_0000_0000_0000;

  // one queued word plus everything the back end needs to finish it
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] len;
    logic [POS_W-1:0]  pos;
    logic              wide;
    logic              last;
    logic              marker_done;
  } hmp_entry_t;

  typedef enum logic {
    ST_HEAD,
    ST_PAD
  } hmp_state_t;

endpackage

/* rtl/core/hash_message_padder_core.sv */
// hash_message_padder_core: pads a 64-bit word stream for md5, sha-256 or sha-512
// an accepted word is written into the queue, then registered into the output word by the back end
// throughput: one output word per cycle while m_tready is high; a last word is followed
// by its padding words up to the length word, all emitted by the back end
// reset: rst synchronous, clears counters, queue and output; hash_mode to sha-256
// depends on hmp_pkg, hmp_front, hmp_queue, hmp_back
module hash_message_padder_core #(
  parameter int QUEUE_DEPTH = hmp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hmp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hmp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hmp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [63:0]                    s_tdata,  // data_word[63:0]
  input  logic [3:0]                     s_tuser,  // valid_bytes[3:0]
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [63:0]                    m_tdata,  // out_word[63:0]
  output logic                           m_tuser,  // block_end
  output logic                           m_tlast
);
  import hmp_pkg::*;

  logic [MODE_W-1:0] hash_mode;
  logic              push;
  hmp_entry_t        push_entry;
  logic              queue_full;
  logic              pop;
  logic              head_valid;
  hmp_entry_t        head_entry;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode <= MODE_SHA256;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HASH_MODE)) begin
      hash_mode <= pwdata[MODE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_HASH_MODE) ? {{(CFG_DATA_W-MODE_W){1'b0}}, hash_mode} : '0;

  hmp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .hash_mode   (hash_mode),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .data_word   (s_tdata),
    .valid_bytes (s_tuser),
    .last_word   (s_tlast),
    .push        (push),
    .push_entry  (push_entry),
    .queue_full  (queue_full)
  );

  hmp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  hmp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_word    (m_tdata),
    .block_end   (m_tuser),
    .message_end (m_tlast)
  );

endmodule

/* rtl/core/hmp_front.sv */
// hmp_front: accepts message words, keeps the byte and block counters,
// builds the last word and length field; depends on hmp_pkg
module hmp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hmp_pkg::MODE_W-1:0]   hash_mode,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hmp_pkg::WORD_W-1:0]   data_word,
  input  logic [hmp_pkg::VBYTES_W-1:0] valid_bytes,
  input  logic                         last_word,
  output logic                         push,
  output hmp_pkg::hmp_entry_t          push_entry,
  input  logic                         queue_full
);
  import hmp_pkg::*;

  logic [BYTE_COUNT_W-1:0] byte_count;
  logic [POS_W-1:0]        word_in_block;
  logic                    wide;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        pos_max;
  logic [VBYTES_W-1:0]     v_sat;
  logic [VBYTES_W-1:0]     v_eff;
  logic [BYTE_COUNT_W-1:0] byte_sum;
  logic [WORD_W-1:0]       len_raw;
  logic [WORD_W-1:0]       len_swapped;
  logic [WORD_W-1:0]       last_data;

  assign wide     = hash_mode[1];
  assign pos      = wide ? word_in_block : {1'b0, word_in_block[POS_W-2:0]};
  assign pos_max  = wide ? POS_LAST_WIDE : POS_LAST_NARROW;
  assign v_sat    = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
  assign v_eff    = last_word ? v_sat : 4'd8;
  assign byte_sum = byte_count + {{(BYTE_COUNT_W-VBYTES_W){1'b0}}, v_eff};
  assign len_raw  = {byte_sum, 3'b000};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      len_swapped[8*i +: 8] = len_raw[8*(7-i) +: 8];
      // byte i counts from the top of the word
      if (4'(i) < v_sat) begin
        last_data[WORD_W-8-8*i +: 8] = data_word[WORD_W-8-8*i +: 8];
      end else if (4'(i) == v_sat) begin
        last_data[WORD_W-8-8*i +: 8] = 8'h80;
      end else begin
        last_data[WORD_W-8-8*i +: 8] = 8'h00;
      end
    end
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_entry.word        = last_word ? last_data : data_word;
    push_entry.len         = (hash_mode == MODE_MD5) ? len_swapped : len_raw;
    push_entry.pos         = pos;
    push_entry.wide        = wide;
    push_entry.last        = last_word;
    push_entry.marker_done = v_sat < 4'd8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      word_in_block <= '0;
    end else if (push) begin
      if (last_word) begin
        byte_count    <= '0;
        word_in_block <= '0;
      end else begin
        byte_count    <= byte_sum;
        word_in_block <= (pos == pos_max) ? '0 : pos + 4'd1;
      end
    end
  end

endmodule

/* rtl/core/hmp_queue.sv */
// hmp_queue: small register queue between front and back end
// depends on hmp_pkg for the entry type
module hmp_queue #(
  parameter int DEPTH = hmp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hmp_pkg::hmp_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output hmp_pkg::hmp_entry_t head_entry
);
  import hmp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hmp_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_entry = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/hmp_back.sv */
// hmp_back: emits queued words and runs the padding sequence to the length word
// depends on hmp_pkg
module hmp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  hmp_pkg::hmp_entry_t        head_entry,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hmp_pkg::WORD_W-1:0] out_word,
  output logic                       block_end,
  output logic                       message_end
);
  import hmp_pkg::*;

  hmp_state_t        state;
  hmp_state_t        state_next;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic              marker_done;
  logic              marker_done_next;
  logic              final_blk;
  logic              final_blk_next;
  logic              load;
  logic [WORD_W-1:0] word_w;
  logic              be_w;
  logic              me_w;
  logic [POS_W-1:0]  pos_max;
  logic [POS_W-1:0]  pos_len;
  logic [POS_W-1:0]  pos_cur;

  assign pos_max = head_entry.wide ? POS_LAST_WIDE : POS_LAST_NARROW;
  assign pos_len = head_entry.wide ? POS_LEN_WIDE : POS_LEN_NARROW;
  assign pos_cur = (state == ST_HEAD) ? head_entry.pos : pos;

  always_comb begin
    state_next       = state;
    pos_next         = pos;
    marker_done_next = marker_done;
    final_blk_next   = final_blk;
    pop              = 1'b0;
    load             = 1'b0;
    word_w           = head_entry.word;
    be_w             = (pos_cur == pos_max);
    me_w             = 1'b0;
    if (head_valid && (!out_valid || out_ready)) begin
      load = 1'b1;
      unique case (state)
        ST_HEAD: begin
          if (!head_entry.last) begin
            pop = 1'b1;
          end else begin
            marker_done_next = head_entry.marker_done;
            final_blk_next   = head_entry.marker_done && (pos_cur < pos_len);
            state_next       = ST_PAD;
          end
        end
        ST_PAD: begin
          priority if (!marker_done) begin
            word_w           = MARKER_WORD;
            marker_done_next = 1'b1;
            final_blk_next   = pos_cur < pos_len;
          end else if (final_blk && (pos_cur == pos_max)) begin
            word_w = head_entry.len;
            me_w   = 1'b1;
          end else begin
            word_w = '0;
          end
          if (me_w) begin
            pop        = 1'b1;
            state_next = ST_HEAD;
          end
        end
        default: begin
          state_next = ST_HEAD;
        end
      endcase
      // advance the block position within the padding run
      if (state_next == ST_PAD) begin
        if (pos_cur == pos_max) begin
          pos_next = '0;
          if (marker_done_next) begin
            final_blk_next = 1'b1;
          end
        end else begin
          pos_next = pos_cur + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_HEAD;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    marker_done <= marker_done_next;
    final_blk   <= final_blk_next;
    if (load) begin
      out_word    <= word_w;
      block_end   <= be_w;
      message_end <= me_w;
    end
  end

endmodule

/* test/tb_top.sv */
// tb_top: self-checking testbench for hash_message_padder_core (md5 / sha-256 / sha-512 padding)
// runs a directed request table, then random messages under all modes with random stalls
// depends on hmp_pkg and the hash_message_padder_core rtl only
`timescale 1ns / 1ps

module tb_top;
  import hmp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SHA512     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SHA512_ALT = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] HASH_MODE_ADDR = {REG_HASH_MODE, 2'b00};
  localparam int ITEM_TARGET = 470;
  localparam int QUIET_TAIL  = 60;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 23;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              blk_end;
    logic              msg_end;
  } pad_word_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [63:0]       data;
    logic [3:0]        vbytes;
    logic              last;
    logic              has_exp;
    logic [63:0]       exp_first;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [63:0]           s_tdata;  // data_word[63:0]
  logic [3:0]            s_tuser;  // valid_bytes[3:0]
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [63:0]           m_tdata;  // out_word[63:0]
  logic                  m_tuser;  // block_end
  logic                  m_tlast;

  // predictor state
  logic [MODE_W-1:0]       mode_shadow;
  logic [BYTE_COUNT_W-1:0] byte_tally;
  logic [POS_W-1:0]        word_pos;
  pad_word_t               padded_q[$];

  int  fail_cnt;
  int  words_checked;
  int  req_cnt;
  int  msg_cnt;
  int  cycle_cnt;
  bit  idle_on;
  bit  hold_req;
  logic [3:0] modes_seen;

  dir_row_t dir_tab[DIR_ROWS];

  hash_message_padder_core DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt,
               padded_q.size());
      $display("hash_message_padder_core regression: fail");
      $finish;
    end
  end

  // expected padded words for one accepted request; a typed first word overrides
  function automatic void pad_predict(input logic [63:0] din, input logic [3:0] vb,
                                      input logic lst, input logic has_exp,
                                      input logic [63:0] exp_first);
    int        blk_w;
    int        len_w;
    int        p;
    int        n;
    int        vn;
    logic [63:0] keep;
    logic [63:0] w;
    logic [63:0] bit_len;
    logic [63:0] swapped;
    logic        marker_done;
    logic        final_blk;
    logic        me;
    pad_word_t   pw;
    blk_w = mode_shadow[1] ? 16 : 8;
    len_w = mode_shadow[1] ? 2 : 1;
    p = int'(word_pos) & (blk_w - 1);
    if (!lst) begin
      byte_tally = byte_tally + 61'd8;
      word_pos = (p == blk_w - 1) ? '0 : POS_W'(p + 1);
      pw = '{has_exp ? exp_first : din, p == blk_w - 1, 1'b0};
      padded_q.push_back(pw);
      return;
    end
    vn = (vb > 4'd8) ? 8 : int'(vb);
    byte_tally = byte_tally + BYTE_COUNT_W'(vn);
    bit_len = {byte_tally, 3'b000};
    if (mode_shadow == MODE_MD5) begin
      for (int i = 0; i < 8; i++) swapped[8*i +: 8] = bit_len[56-8*i +: 8];
      bit_len = swapped;
    end
    keep = (vn == 0) ? 64'h0 : (~64'h0 << (64 - 8 * vn));
    w = din & keep;
    marker_done = (vn < 8);
    if (marker_done) w = w | (64'h80 << (56 - 8 * vn));
    final_blk = marker_done && (p < blk_w - len_w);
    pw = '{has_exp ? exp_first : w, p == blk_w - 1, 1'b0};
    padded_q.push_back(pw);
    n = 1;
    p++;
    if (p == blk_w) begin
      p = 0;
      if (marker_done) final_blk = 1'b1;
    end
    while (n < 18) begin
      w = '0;
      me = 1'b0;
      if (!marker_done) begin
        w = MARKER_WORD;
        marker_done = 1'b1;
        final_blk = (p < blk_w - len_w);
      end else if (final_blk && p == blk_w - 1) begin
        w = bit_len;
        me = 1'b1;
      end
      pw = '{w, p == blk_w - 1, me};
      padded_q.push_back(pw);
      n++;
      if (me) break;
      p++;
      if (p == blk_w) begin
        p = 0;
        if (marker_done) final_blk = 1'b1;
      end
    end
    byte_tally = '0;
    word_pos = '0;
  endfunction

  // one stream request, with an optional idle burst in front
  task automatic send_req(input logic [63:0] din, input logic [3:0] vb, input logic lst,
                          input logic has_exp, input logic [63:0] exp_first);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= din;
    s_tuser  <= vb;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    pad_predict(din, vb, lst, has_exp, exp_first);
    req_cnt++;
    if (lst) msg_cnt++;
  endtask

  // wait until every expected word is out, plus the pipeline latency
  task automatic drain();
    s_tvalid <= 1'b0;
    while (padded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // optional write of hash_mode, then read back
  task automatic cfg_access(input bit wr, input logic [MODE_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    paddr   <= HASH_MODE_ADDR;
    pwrite  <= wr;
    pwdata  <= CFG_DATA_W'(val);
    if (wr) begin
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      mode_shadow = val;
      modes_seen[val] = 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(mode_shadow)) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("hash_mode read: expected %0d, got %h", mode_shadow, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 64'h0;
    if (r == 1) return ~64'h0;
    return {$urandom, $urandom};
  endfunction

  // receiver: checks each accepted word and throttles m_tready
  initial begin : receiver
    int hold_cnt;
    pad_word_t exp_w;
    pad_word_t got_w;
    hold_cnt = 0;
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got_w = '{m_tdata, m_tuser, m_tlast};
        if (padded_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected word %h block_end %b message_end %b", m_tdata, m_tuser,
                     m_tlast);
        end else begin
          exp_w = padded_q.pop_front();
          words_checked++;
          if (got_w !== exp_w) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("word %0d: expected %h/%b/%b, got %h/%b/%b", words_checked,
                       exp_w.word, exp_w.blk_end, exp_w.msg_end,
                       got_w.word, got_w.blk_end, got_w.msg_end);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        // long back-pressure so the input side fills and stalls
        hold_req = 1'b0;
        hold_cnt = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        hold_cnt = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n_msgs;
    int body;
    logic [MODE_W-1:0] pick;
    logic [3:0] vb;
    dir_tab = '{
      '{MODE_SHA256,     64'h0,                   4'd0,  1'b1, 1'b1, 64'h8000_0000_0000_0000},
      '{MODE_SHA256,     64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{MODE_SHA256,     64'h0123_4567_89AB_CDEF, 4'd8,  1'b1, 1'b1, 64'h0123_4567_89AB_CDEF},
      '{MODE_SHA256,     64'h1122_3344_5566_7788, 4'd3,  1'b1, 1'b1, 64'h1122_3380_0000_0000},
      '{MODE_SHA256,     64'hFFFF_FFFF_FFFF_FFFF, 4'd7,  1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FF80},
      '{MODE_SHA256,     64'hAAAA_AAAA_AAAA_AAAA, 4'd15, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA},
      '{MODE_SHA256,     64'h5555_5555_5555_5555, 4'd9,  1'b1, 1'b1, 64'h5555_5555_5555_5555},
      '{MODE_SHA256,     64'hFFFF_FFFF_FFFF_FFFF, 4'd1,  1'b1, 1'b1, 64'hFF80_0000_0000_0000},
      '{MODE_MD5,        64'h6162_6364_6566_6768, 4'd1,  1'b1, 1'b1, 64'h6180_0000_0000_0000},
      '{MODE_MD5,        64'h0,                   4'd8,  1'b0, 1'b0, 64'h0},
      '{MODE_MD5,        64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 64'h0},
      '{MODE_MD5,        64'hDEAD_BEEF_0BAD_F00D, 4'd3,  1'b0, 1'b0, 64'h0},
      '{MODE_MD5,        64'h8000_0000_0000_0001, 4'd0,  1'b0, 1'b0, 64'h0},
      '{MODE_MD5,        64'h0F0F_0F0F_F0F0_F0F0, 4'd7,  1'b0, 1'b0, 64'h0},
      '{MODE_MD5,        64'h3333_CCCC_3333_CCCC, 4'd1,  1'b0, 1'b0, 64'h0},
      '{MODE_MD5,        64'h7FFF_FFFF_FFFF_FFFE, 4'd12, 1'b0, 1'b0, 64'h0},
      // full last word at the end of a block pushes the marker into a new block
      '{MODE_MD5,        64'hFEDC_BA98_7654_3210, 4'd8,  1'b1, 1'b1, 64'hFEDC_BA98_7654_3210},
      '{MODE_SHA512,     64'h0,                   4'd0,  1'b1, 1'b1, 64'h8000_0000_0000_0000},
      '{MODE_SHA512_ALT, 64'h1234_5678_9ABC_DEF0, 4'd5,  1'b1, 1'b1, 64'h1234_5678_9A80_0000},
      '{MODE_SHA512,     64'h0000_FFFF_0000_FFFF, 4'd2,  1'b0, 1'b0, 64'h0},
      '{MODE_SHA512,     64'hFFFF_0000_FFFF_0000, 4'd4,  1'b0, 1'b0, 64'h0},
      '{MODE_SHA512,     64'h0102_0304_0506_0708, 4'd6,  1'b0, 1'b0, 64'h0},
      // mode switched to md5 in the middle of a sha-512 message
      '{MODE_MD5,        64'hC3C3_C3C3_C3C3_C3C3, 4'd2,  1'b1, 1'b1, 64'hC3C3_8000_0000_0000}
    };
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    s_tlast  <= 1'b0;
    mode_shadow = MODE_SHA256;
    byte_tally  = '0;
    word_pos    = '0;
    modes_seen  = 4'b0010;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_access(1'b0, MODE_SHA256);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != mode_shadow) begin
        drain();
        cfg_access(1'b1, dir_tab[i].mode);
      end
      send_req(dir_tab[i].data, dir_tab[i].vbytes, dir_tab[i].last,
               dir_tab[i].has_exp, dir_tab[i].exp_first);
    end

    phase = 0;
    while (req_cnt < ITEM_TARGET) begin
      drain();
      pick = (phase < 4) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 3));
      cfg_access(1'b1, pick);
      idle_on = (req_cnt < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if (phase == 5) hold_req = 1'b1;
      n_msgs = $urandom_range(1, 4);
      for (int m = 0; m < n_msgs; m++) begin
        if (phase == 5 && m == 0) body = 40;
        else if ($urandom_range(0, 4) == 0) body = $urandom_range(12, 34);
        else body = $urandom_range(0, 11);
        for (int k = 0; k < body; k++)
          send_req(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, 64'h0);
        vb = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        send_req(rand_word(), vb, 1'b1, 1'b0, 64'h0);
      end
      // now and then leave a message open across the next mode change
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 5))
          send_req(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, 64'h0);
      phase++;
    end

    idle_on = 1'b0;
    s_tvalid <= 1'b0;
    while (padded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d requests in %0d messages, %0d padded words checked",
             req_cnt, msg_cnt, words_checked);
    $display("hash modes written %b, %0d random phases, %0d mismatches",
             modes_seen, phase, fail_cnt);
    if (fail_cnt == 0) begin
      $display("hash_message_padder_core regression: pass");
    end else begin
      $display("hash_message_padder_core regression: fail");
    end
    $finish;
  end

endmodule
